### sv/acbc_pkg.sv
package acbc_pkg;

	localparam int BEEP_ON_TICKS_DEF   = 50;
	localparam int BEEP_OFF_TICKS_DEF  = 50;
	localparam int REST_TICKS_DEF      = 500;
	localparam int BEEPS_PER_ROUND_DEF = 4;

	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int TICK_W   = 10;
	localparam int BEEP_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	localparam logic [HOUR_W-1:0] NONE_HOUR = 5'd31;
	localparam logic [TICK_W-1:0] TICK_MAX  = 10'd1023;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WAKE_HOUR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_MINUTE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHIME_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHIME_FIRST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHIME_LAST   = 3'd5;

	localparam logic [HOUR_W-1:0] CHIME_FIRST_RST = 5'd8;
	localparam logic [HOUR_W-1:0] CHIME_LAST_RST  = 5'd20;

endpackage

### sv/alarm_chime_beep_controller_core.sv
// alarm clock controller: hourly chime and alarm beep cadence
// input channel (in_valid/in_ready): opcode 1 is a time update carrying
//   hour_now and minute_now, opcode 0 is a one millisecond tick
// output channel (out_valid/out_ready): one result per request with
//   buzzer_on, alarm_active and chime_pulse as they stand after that request
// configuration: cfg_write with cfg_index and cfg_data; the user must write it
//   only while no request is in flight, as the block itself does not enforce it
// a request is registered in the input stage on acceptance and its result is
//   registered in the result register when that stage advances to the output
// throughput is one request per cycle unless the receiver stalls; the state update is a
//   single pass of compare and increment logic between the input and result registers
// when the receiver stalls, the held result blocks the input stage, which
//   still takes one more request; in_ready drops once both stages are full
// reset clears the alarm and cadence state, sets the chime window to 8..20,
//   marks no hour as chimed and empties both stages
module alarm_chime_beep_controller_core
	import acbc_pkg::*;
#(
	parameter int BEEP_ON_TICKS   = BEEP_ON_TICKS_DEF,
	parameter int BEEP_OFF_TICKS  = BEEP_OFF_TICKS_DEF,
	parameter int REST_TICKS      = REST_TICKS_DEF,
	parameter int BEEPS_PER_ROUND = BEEPS_PER_ROUND_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [HOUR_W-1:0]     hour_now,
	input  logic [MINUTE_W-1:0]   minute_now,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  buzzer_on,
	output logic                  alarm_active,
	output logic                  chime_pulse
);

	localparam logic [TICK_W-1:0] ON_LIM   = TICK_W'(BEEP_ON_TICKS);
	localparam logic [TICK_W-1:0] OFF_LIM  = TICK_W'(BEEP_OFF_TICKS);
	localparam logic [TICK_W-1:0] REST_LIM = TICK_W'(REST_TICKS);
	localparam logic [BEEP_W-1:0] BEEPS    = BEEP_W'(BEEPS_PER_ROUND);

	logic [HOUR_W-1:0]   wake_hour_q;
	logic [MINUTE_W-1:0] alarm_minute_q;
	logic                alarm_enable_q;
	logic                chime_enable_q;
	logic [HOUR_W-1:0]   chime_first_q;
	logic [HOUR_W-1:0]   chime_last_q;

	logic [HOUR_W-1:0]   last_chimed_q;
	logic                running_q;
	logic                fired_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [BEEP_W-1:0]   beeps_q;
	logic                buzzer_q;

	logic                valid_s1;
	logic                opcode_s1;
	logic [HOUR_W-1:0]   hour_s1;
	logic [MINUTE_W-1:0] minute_s1;

	logic                out_valid_q;
	logic                advance;
	logic                fire;

	logic [HOUR_W-1:0]   last_chimed_d;
	logic                running_d;
	logic                fired_d;
	logic [TICK_W-1:0]   ticks_d;
	logic [BEEP_W-1:0]   beeps_d;
	logic                buzzer_d;
	logic                pulse_d;
	logic                match;
	logic                in_window;
	logic [TICK_W-1:0]   ticks_inc;

	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wake_hour_q    <= '0;
			alarm_minute_q <= '0;
			alarm_enable_q <= 1'b0;
			chime_enable_q <= 1'b0;
			chime_first_q  <= CHIME_FIRST_RST;
			chime_last_q   <= CHIME_LAST_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WAKE_HOUR:    wake_hour_q    <= cfg_data[HOUR_W-1:0];
				REG_ALARM_MINUTE: alarm_minute_q <= cfg_data[MINUTE_W-1:0];
				REG_ALARM_ENABLE: alarm_enable_q <= cfg_data[0];
				REG_CHIME_ENABLE: chime_enable_q <= cfg_data[0];
				REG_CHIME_FIRST:  chime_first_q  <= cfg_data[HOUR_W-1:0];
				REG_CHIME_LAST:   chime_last_q   <= cfg_data[HOUR_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			hour_s1   <= hour_now;
			minute_s1 <= minute_now;
		end
	end

	always_comb begin
		last_chimed_d = last_chimed_q;
		running_d     = running_q;
		fired_d       = fired_q;
		ticks_d       = ticks_q;
		beeps_d       = beeps_q;
		buzzer_d      = buzzer_q;
		pulse_d       = 1'b0;
		match         = (wake_hour_q == hour_s1) && (alarm_minute_q == minute_s1);
		ticks_inc     = (ticks_q != TICK_MAX) ? ticks_q + 1'b1 : ticks_q;

		if (chime_first_q <= chime_last_q) begin
			in_window = (hour_s1 >= chime_first_q) && (hour_s1 <= chime_last_q);
		end else begin
			in_window = (hour_s1 >= chime_first_q) || (hour_s1 <= chime_last_q);
		end

		if (opcode_s1 == OP_UPDATE) begin
			// hourly chime, skipped when the alarm owns this hour:00
			if (chime_enable_q && minute_s1 == '0 && hour_s1 != last_chimed_q &&
			    (!alarm_enable_q || alarm_minute_q != '0 || wake_hour_q != hour_s1)) begin
				pulse_d       = in_window;
				last_chimed_d = hour_s1;
			end
			if (match && !fired_q && alarm_enable_q) begin
				running_d = 1'b1;
				fired_d   = 1'b1;
				ticks_d   = '0;
				beeps_d   = '0;
			end
			if (!match) begin
				if (running_q) begin
					running_d = 1'b0;
					buzzer_d  = 1'b0;
				end
				fired_d = 1'b0;
			end
		end else if (running_q) begin
			ticks_d = ticks_inc;
			priority if (buzzer_q) begin
				if (ticks_inc > ON_LIM) begin
					buzzer_d = 1'b0;
					beeps_d  = beeps_q + 1'b1;
					ticks_d  = '0;
				end
			end else if (beeps_q < BEEPS) begin
				if (ticks_inc > OFF_LIM) begin
					buzzer_d = 1'b1;
					ticks_d  = '0;
				end
			end else begin
				if (ticks_inc > REST_LIM) begin
					buzzer_d = 1'b1;
					ticks_d  = '0;
					beeps_d  = '0;
				end
			end
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_chimed_q <= NONE_HOUR;
			running_q     <= 1'b0;
			fired_q       <= 1'b0;
			ticks_q       <= '0;
			beeps_q       <= '0;
			buzzer_q      <= 1'b0;
		end else if (fire) begin
			last_chimed_q <= last_chimed_d;
			running_q     <= running_d;
			fired_q       <= fired_d;
			ticks_q       <= ticks_d;
			beeps_q       <= beeps_d;
			buzzer_q      <= buzzer_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			buzzer_on    <= buzzer_d;
			alarm_active <= running_d;
			chime_pulse  <= pulse_d;
		end
	end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

import acbc_pkg::*;

typedef struct packed {
	logic buzzer_on;
	logic alarm_active;
	logic chime_pulse;
} clock_outcome_t;

class alarm_scoreboard;
	logic [HOUR_W-1:0]   wake_hour;
	logic [MINUTE_W-1:0] alarm_minute;
	logic                alarm_en;
	logic                chime_en;
	logic [HOUR_W-1:0]   chime_first;
	logic [HOUR_W-1:0]   chime_last;

	logic [HOUR_W-1:0]   last_chimed;
	logic                running;
	logic                fired;
	logic [TICK_W-1:0]   phase_ticks;
	logic [BEEP_W-1:0]   beeps_done;
	logic                buzzer;

	clock_outcome_t pending_outcomes[$];
	int mismatches;
	int checked;
	int ticks;
	int updates;
	int alarm_starts;
	int chimes;
	int full_rounds;

	function new();
		wake_hour    = '0;
		alarm_minute = '0;
		alarm_en     = 1'b0;
		chime_en     = 1'b0;
		chime_first  = CHIME_FIRST_RST;
		chime_last   = CHIME_LAST_RST;
		last_chimed  = NONE_HOUR;
		running      = 1'b0;
		fired        = 1'b0;
		phase_ticks  = '0;
		beeps_done   = '0;
		buzzer       = 1'b0;
		mismatches   = 0;
		checked      = 0;
		ticks        = 0;
		updates      = 0;
		alarm_starts = 0;
		chimes       = 0;
		full_rounds  = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
		REG_WAKE_HOUR:    wake_hour    = data[HOUR_W-1:0];
		REG_ALARM_MINUTE: alarm_minute = data[MINUTE_W-1:0];
		REG_ALARM_ENABLE: alarm_en     = data[0];
		REG_CHIME_ENABLE: chime_en     = data[0];
		REG_CHIME_FIRST:  chime_first  = data[HOUR_W-1:0];
		REG_CHIME_LAST:   chime_last   = data[HOUR_W-1:0];
		default: ;
		endcase
	endfunction

	function void note_request(logic op, logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn);
		logic pulse;
		logic in_window;
		logic match;
		pulse = 1'b0;
		if (op == OP_UPDATE) begin
			updates++;
			// chime is skipped when the enabled alarm sits on this hour:00
			if (chime_en && mn == 0 && hr != last_chimed &&
			    (!alarm_en || alarm_minute != 0 || wake_hour != hr)) begin
				if (chime_first <= chime_last)
					in_window = hr >= chime_first && hr <= chime_last;
				else
					in_window = hr >= chime_first || hr <= chime_last;
				pulse = in_window;
				last_chimed = hr;
			end
			match = wake_hour == hr && alarm_minute == mn;
			if (match && !fired && alarm_en) begin
				running     = 1'b1;
				fired       = 1'b1;
				phase_ticks = '0;
				beeps_done  = '0;
				alarm_starts++;
			end
			if (!match) begin
				if (running) begin
					running = 1'b0;
					buzzer  = 1'b0;
				end
				fired = 1'b0;
			end
		end else begin
			ticks++;
			if (running) begin
				if (phase_ticks != TICK_MAX)
					phase_ticks++;
				if (buzzer) begin
					if (phase_ticks > BEEP_ON_TICKS_DEF) begin
						buzzer      = 1'b0;
						beeps_done++;
						phase_ticks = '0;
					end
				end else if (beeps_done < BEEPS_PER_ROUND_DEF) begin
					if (phase_ticks > BEEP_OFF_TICKS_DEF) begin
						buzzer      = 1'b1;
						phase_ticks = '0;
					end
				end else if (phase_ticks > REST_TICKS_DEF) begin
					buzzer      = 1'b1;
					phase_ticks = '0;
					beeps_done  = '0;
					full_rounds++;
				end
			end
		end
		chimes += pulse;
		pending_outcomes.push_back('{buzzer, running, pulse});
	endfunction

	task report_mismatch(string what);
		mismatches++;
		if (mismatches <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task check_result(logic buz, logic act, logic chm);
		clock_outcome_t want;
		if (pending_outcomes.size() == 0) begin
			report_mismatch($sformatf("unexpected result buzzer_on=%b alarm_active=%b chime_pulse=%b",
				buz, act, chm));
			return;
		end
		want = pending_outcomes.pop_front();
		checked++;
		if (buz !== want.buzzer_on)
			report_mismatch($sformatf("result %0d buzzer_on %b, expected %b",
				checked, buz, want.buzzer_on));
		if (act !== want.alarm_active)
			report_mismatch($sformatf("result %0d alarm_active %b, expected %b",
				checked, act, want.alarm_active));
		if (chm !== want.chime_pulse)
			report_mismatch($sformatf("result %0d chime_pulse %b, expected %b",
				checked, chm, want.chime_pulse));
	endtask
endclass

module tb;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1550;
	localparam int PHASES         = 7;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  opcode     = OP_TICK;
	logic [HOUR_W-1:0]     hour_now   = '0;
	logic [MINUTE_W-1:0]   minute_now = '0;
	logic                  out_ready  = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  buzzer_on;
	logic                  alarm_active;
	logic                  chime_pulse;

	alarm_scoreboard sb;

	int gap_pct          = 0;
	int stall_pct        = 0;
	int requests_sent    = 0;
	int settings_applied = 0;
	int idle_cycles      = 0;
	int phase_stop       = 0;
	bit long_round_due   = 1'b0;

	logic [HOUR_W-1:0]   al_hour    = '0;
	logic [MINUTE_W-1:0] al_minute  = '0;
	logic [HOUR_W-1:0]   clock_hour = '0;

	alarm_chime_beep_controller_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.hour_now(hour_now),
		.minute_now(minute_now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buzzer_on(buzzer_on),
		.alarm_active(alarm_active),
		.chime_pulse(chime_pulse)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(opcode, hour_now, minute_now);
			if (out_valid && out_ready)
				sb.check_result(buzzer_on, alarm_active, chime_pulse);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_request(logic op, logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		hour_now   <= hr;
		minute_now <= mn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic send_update(logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn);
		send_request(OP_UPDATE, hr, mn);
	endtask

	// tick payload is ignored by the block, so it carries random bits
	task automatic send_ticks(int n);
		logic [HOUR_W-1:0]   hr;
		logic [MINUTE_W-1:0] mn;
		repeat (n) begin
			hr = HOUR_W'($urandom_range(0, 31));
			mn = MINUTE_W'($urandom_range(0, 63));
			send_request(OP_TICK, hr, mn);
		end
	endtask

	task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_settings(logic [HOUR_W-1:0] ah, logic [MINUTE_W-1:0] am,
		logic aen, logic cen, logic [HOUR_W-1:0] first, logic [HOUR_W-1:0] last);
		in_valid <= 1'b0;
		// let the monitor note the last accepted request first
		@(posedge clk);
		while (sb.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		program_reg(REG_WAKE_HOUR, CFG_DATA_W'(ah));
		program_reg(REG_ALARM_MINUTE, am);
		program_reg(REG_ALARM_ENABLE, CFG_DATA_W'(aen));
		program_reg(REG_CHIME_ENABLE, CFG_DATA_W'(cen));
		program_reg(REG_CHIME_FIRST, CFG_DATA_W'(first));
		program_reg(REG_CHIME_LAST, CFG_DATA_W'(last));
		cfg_write <= 1'b0;
		al_hour   = ah;
		al_minute = am;
		settings_applied++;
	endtask

	task automatic alarm_episode();
		int segments;
		int len;
		int pick;
		logic [MINUTE_W-1:0] other;
		send_update(al_hour, al_minute);
		segments = $urandom_range(1, 4);
		repeat (segments) begin
			pick = $urandom_range(0, 99);
			if (long_round_due) begin
				// past the rest, into the next round
				len = 960;
				long_round_due = 1'b0;
			end else begin
				if (pick < 70)
					len = $urandom_range(1, 120);
				else if (pick < 95)
					len = $urandom_range(120, 400);
				else
					len = $urandom_range(400, 700);
				// keep the phase near its share of requests
				if (requests_sent + len > phase_stop)
					len = (phase_stop > requests_sent) ? phase_stop - requests_sent : 1;
			end
			send_ticks(len);
			if ($urandom_range(0, 99) < 30)
				send_update(al_hour, al_minute);
		end
		if ($urandom_range(0, 99) < 80) begin
			if (al_minute == 59)
				other = '0;
			else
				other = al_minute + 6'd1;
			send_update(al_hour, other);
			send_ticks($urandom_range(0, 5));
		end
	endtask

	task automatic chime_episode();
		int n;
		int pick;
		logic [MINUTE_W-1:0] mn;
		n = $urandom_range(2, 6);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				if (clock_hour >= 23)
					clock_hour = '0;
				else
					clock_hour = clock_hour + 5'd1;
			end else if (pick < 65)
				clock_hour = al_hour;
			else if (pick < 80)
				clock_hour = HOUR_W'($urandom_range(0, 23));
			if ($urandom_range(0, 99) < 85)
				mn = '0;
			else
				mn = MINUTE_W'($urandom_range(0, 59));
			send_update(clock_hour, mn);
			if ($urandom_range(0, 99) < 25)
				send_ticks($urandom_range(1, 3));
		end
	endtask

	task automatic noise_episode();
		int n;
		logic op;
		logic [HOUR_W-1:0]   hr;
		logic [MINUTE_W-1:0] mn;
		n = $urandom_range(3, 10);
		repeat (n) begin
			op = ($urandom_range(0, 1) == 1) ? OP_UPDATE : OP_TICK;
			hr = HOUR_W'($urandom_range(0, 23));
			mn = MINUTE_W'($urandom_range(0, 59));
			send_request(op, hr, mn);
		end
	endtask

	task automatic run_phase(int budget);
		int stop_at;
		int pick;
		stop_at = requests_sent + budget;
		phase_stop = stop_at;
		if (long_round_due)
			alarm_episode();
		while (requests_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				alarm_episode();
			else if (pick < 70)
				chime_episode();
			else
				noise_episode();
		end
	endtask

	initial begin
		int p;
		int budget;
		int directed_done;
		logic [HOUR_W-1:0]   rh;
		logic [MINUTE_W-1:0] rm;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: alarm and chime both off
		send_request(OP_TICK, '0, '0);
		send_update(8, 0);
		apply_settings(12, 0, 1, 1, 8, 20);
		send_update(31, 0);
		send_update(5, 0);
		send_update(5, 0);
		send_update(8, 0);
		send_update(8, 0);
		send_update(12, 0);
		send_ticks(2);
		send_update(12, 0);
		send_update(12, 1);
		send_request(OP_TICK, 31, 63);
		send_update(23, 63);
		send_update(20, 0);
		send_update(21, 0);
		send_update(16, 32);
		send_update(12, 0);
		send_ticks(1);
		send_update(11, 59);
		directed_done = requests_sent;

		for (p = 0; p < PHASES; p++) begin
			if (p == 2 || p == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 10 * $urandom_range(1, 4);
				stall_pct = 10 * $urandom_range(0, 4);
			end
			case (p)
			0: apply_settings(7, 30, 1, 1, 8, 20);
			1: apply_settings(0, 0, 1, 1, 22, 6);
			2: apply_settings(23, 59, 1, 1, 0, 23);
			3: apply_settings(12, 0, 0, 1, 23, 0);
			4: apply_settings(15, 0, 1, 0, 5, 5);
			default: begin
				rh = HOUR_W'($urandom_range(0, 23));
				rm = ($urandom_range(0, 1) == 1) ? 6'd0 : 6'($urandom_range(0, 59));
				apply_settings(rh, rm, 1'b1, 1'($urandom_range(0, 1)),
					HOUR_W'($urandom_range(0, 23)), HOUR_W'($urandom_range(0, 23)));
			end
			endcase
			budget = (directed_done + RANDOM_ITEMS - requests_sent) / (PHASES - p);
			if (budget < 60)
				budget = 60;
			long_round_due = (p == 0);
			run_phase(budget);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d requests (%0d ticks, %0d time updates), %0d results checked, %0d settings",
			requests_sent, sb.ticks, sb.updates, sb.checked, settings_applied);
		$display("run: %0d alarm starts, %0d chime pulses, %0d full beep rounds, %0d mismatches",
			sb.alarm_starts, sb.chimes, sb.full_rounds, sb.mismatches);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

### filelist.f
sv/acbc_pkg.sv
sv/alarm_chime_beep_controller_core.sv
tb/sv/tb.sv
